// File: rtl/llwd_pkg.sv
// Shared constants for the least-loaded worker dispatcher.
// No dependencies.
package llwd_pkg;

	localparam int TIME_W   = 48;
	localparam int DUR_W    = 32;
	localparam int OUT_ID_W = 6;
	localparam int CFG_W    = 7;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// register index, taken from paddr[2]
	localparam logic REG_NUM_WORKERS = 1'b0;

endpackage

// File: rtl/llwd_job_if.sv
// Job request channel: valid/ready handshake carrying one job duration.
// Depends on llwd_pkg.
interface llwd_job_if;
	logic                       valid;
	logic                       ready;
	logic [llwd_pkg::DUR_W-1:0] job_duration;

	modport source (output valid, output job_duration, input ready);
	modport sink   (input valid, input job_duration, output ready);
endinterface

// File: rtl/llwd_res_if.sv
// Result channel: valid/ready handshake carrying worker number and start tick.
// Depends on llwd_pkg.
interface llwd_res_if;
	logic                          valid;
	logic                          ready;
	logic [llwd_pkg::OUT_ID_W-1:0] assigned_worker;
	logic [llwd_pkg::TIME_W-1:0]   start_time;

	modport source (output valid, output assigned_worker, output start_time, input ready);
	modport sink   (input valid, input assigned_worker, input start_time, output ready);
endinterface

// File: rtl/llwd_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module llwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                     rdata_a,
	output logic [WIDTH-1:0]                     rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: rtl/least_loaded_worker_dispatcher.sv
// Least-loaded worker dispatcher: top level, config port, sift-down sequencer.
// Depends on llwd_pkg, llwd_job_if, llwd_res_if, llwd_ram.
//
// Usage: each request on the job channel carries a job duration. The job goes
// to the worker that becomes free earliest (ties to the lowest number); the
// result channel returns that worker and the job's start tick. Free times
// saturate at 2^48-1.
// The worker count is written over the APB port (register 0, byte address 0)
// from pwdata[6:0]; 0 becomes 1, above MAX_WORKERS becomes MAX_WORKERS. Writing it
// restarts all workers at tick 0. Write it only while the block is idle.
// The result is registered and valid in the cycle after the request is taken.
// Sifting: after a request the root is sifted down through the heap memory,
// one level at a time in ST_READ (child read), then ST_CMP (compare and
// write back), visiting L <= floor(log2(num_workers))+1 levels, the last one
// finding no smaller child; no new request is taken until it is back in ST_IDLE.
// Reset: one worker, all free at tick 0; no clearing pass, entries never
// written since reset or the last count write read as their initial value.
// A stalled result holds; no new request is taken until it has been taken.
module least_loaded_worker_dispatcher #(
	parameter int MAX_WORKERS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	llwd_job_if.sink                      job,
	llwd_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [llwd_pkg::APB_AW-1:0]   paddr,
	input  logic [llwd_pkg::APB_DW-1:0]   pwdata,
	output logic [llwd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int AW    = MAX_WORKERS > 1 ? $clog2(MAX_WORKERS) : 1;
	localparam int CNT_W = $clog2(MAX_WORKERS + 1);
	localparam int CH_W  = AW + 2;
	localparam int TW    = llwd_pkg::TIME_W;

	typedef struct packed {
		logic [TW-1:0] free_time;
		logic [AW-1:0] worker;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     n_q;
	logic [MAX_WORKERS-1:0] valid_q;
	entry_t               root_q;
	entry_t               item_q;
	logic [AW-1:0]        pos_q;
	logic                 res_valid_q;
	logic [llwd_pkg::OUT_ID_W-1:0] res_worker_q;
	logic [TW-1:0]        res_time_q;

	logic [AW-1:0]        l_addr_s1, r_addr_s1;
	logic                 has_l_s1, has_r_s1, vl_s1, vr_s1;

	logic                 cfg_wr;
	logic [llwd_pkg::CFG_W-1:0] cfg_v;
	logic [CNT_W-1:0]     n_new;
	logic                 job_take;
	logic [TW:0]          sum;
	entry_t               new_item;
	logic [CH_W-1:0]      left_c, right_c;
	entry_t               rd_a, rd_b, l_ent, r_ent;
	logic                 lt_l, lt_r, r_lt_l;
	logic                 take_l, take_r;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	entry_t               ram_wdata;
	logic [AW+5:0]        id_ext;

	// config port
	assign pready = 1'b1;
	assign prdata = llwd_pkg::APB_DW'(n_q);
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == llwd_pkg::REG_NUM_WORKERS);
	assign cfg_v  = pwdata[llwd_pkg::CFG_W-1:0];

	always_comb begin
		if (cfg_v == '0) begin
			n_new = CNT_W'(1);
		end else if (32'(cfg_v) > 32'(MAX_WORKERS)) begin
			n_new = CNT_W'(MAX_WORKERS);
		end else begin
			n_new = CNT_W'(cfg_v);
		end
	end

	// request side
	assign job.ready = (state_q == ST_IDLE) && (!res_valid_q || res.ready);
	assign job_take  = job.valid && job.ready;
	assign sum       = {1'b0, root_q.free_time} + (TW + 1)'(job.job_duration);
	assign new_item.free_time = sum[TW] ? llwd_pkg::TIME_MAX : sum[TW-1:0];
	assign new_item.worker    = root_q.worker;
	assign id_ext = {6'd0, root_q.worker};

	assign res.valid           = res_valid_q;
	assign res.assigned_worker = res_worker_q;
	assign res.start_time      = res_time_q;

	// children of the hole
	assign left_c  = CH_W'({pos_q, 1'b1});
	assign right_c = left_c + CH_W'(1);

	// read data, untouched entries read as their initial value
	always_comb begin
		l_ent = rd_a;
		r_ent = rd_b;
		if (!vl_s1) begin
			l_ent.free_time = '0;
			l_ent.worker    = l_addr_s1;
		end
		if (!vr_s1) begin
			r_ent.free_time = '0;
			r_ent.worker    = r_addr_s1;
		end
	end

	assign lt_l   = has_l_s1 && (l_ent < item_q);
	assign lt_r   = has_r_s1 && (r_ent < item_q);
	assign r_lt_l = r_ent < l_ent;
	assign take_r = lt_r && (!lt_l || r_lt_l);
	assign take_l = lt_l && !take_r;

	always_comb begin
		ram_we    = (state_q == ST_CMP);
		ram_waddr = pos_q;
		if (take_r) begin
			ram_wdata = r_ent;
		end else if (take_l) begin
			ram_wdata = l_ent;
		end else begin
			ram_wdata = item_q;
		end
	end

	llwd_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_WORKERS)
	) u_heap (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (left_c[AW-1:0]),
		.raddr_b (right_c[AW-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// read-side side info, aligned with the registered RAM output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_addr_s1 <= '0;
			r_addr_s1 <= '0;
			has_l_s1  <= 1'b0;
			has_r_s1  <= 1'b0;
			vl_s1     <= 1'b0;
			vr_s1     <= 1'b0;
		end else if (state_q == ST_READ) begin
			l_addr_s1 <= left_c[AW-1:0];
			r_addr_s1 <= right_c[AW-1:0];
			has_l_s1  <= left_c < CH_W'(n_q);
			has_r_s1  <= right_c < CH_W'(n_q);
			vl_s1     <= valid_q[left_c[AW-1:0]];
			vr_s1     <= valid_q[right_c[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cfg_wr) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= CNT_W'(1);
			root_q       <= '0;
			item_q       <= '0;
			pos_q        <= '0;
			res_valid_q  <= 1'b0;
			res_worker_q <= '0;
			res_time_q   <= '0;
		end else begin
			if (res_valid_q && res.ready && !job_take) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				n_q    <= n_new;
				root_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_take) begin
						res_valid_q  <= 1'b1;
						res_worker_q <= id_ext[5:0];
						res_time_q   <= root_q.free_time;
						item_q       <= new_item;
						pos_q        <= '0;
						state_q      <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (pos_q == '0) begin
						root_q <= ram_wdata;
					end
					if (take_r) begin
						pos_q   <= r_addr_s1;
						state_q <= ST_READ;
					end else if (take_l) begin
						pos_q   <= l_addr_s1;
						state_q <= ST_READ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	a_take_starts_sift: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |=> (state_q == ST_READ) && res_valid_q)
		else $error("sift did not start after a request");

	a_hole_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (CH_W'(pos_q) < CH_W'(n_q)))
		else $error("heap hole beyond worker count");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q != '0) && (32'(n_q) <= 32'(MAX_WORKERS)))
		else $error("worker count out of range");

	a_child_deeper: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) && (take_l || take_r) |=> (pos_q > $past(pos_q)))
		else $error("sift-down did not move down");

endmodule
